[rtl/b64d_pkg.sv]
// shared types, codes and the symbol lookup for the base64 text decoder
// no dependencies; used by every module of the block

package b64d_pkg;

   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned ACC_W       = 18;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 7;

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_PAD = 8'h3D;
   localparam logic [7:0] CHAR_DEL = 8'h7F;

   localparam logic [CSR_IDX_W-1:0] CSR_PADDING_ENABLED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_62       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_63       = 2'd2;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef enum logic [2:0] {
      ERR_NONE           = 3'd0,
      ERR_INVALID_CHAR   = 3'd1,
      ERR_MISSING_PAD    = 3'd2,
      ERR_AFTER_END      = 3'd3,
      ERR_UNEXPECTED_END = 3'd4
   } err_code_type;

   typedef struct packed {
      logic       padding_enabled;
      logic [6:0] symbol_62;
      logic [6:0] symbol_63;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       fill;
      logic [ACC_W-1:0] acc;
      logic             after_end;
      logic             pad_pending;
      logic             drop;
   } dec_state_type;

   typedef struct packed {
      logic [7:0]   out_byte;
      logic         kind;
      err_code_type code;
      logic [7:0]   offending;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type [MAX_RESULTS-1:0] item;
   } result_group_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sym_type;

   function automatic sym_type sym_decode(input logic [7:0] ch, input cfg_type cfg);
      sym_type    s;
      logic [7:0] t;
      s.ok    = 1'b1;
      s.value = '0;
      t       = '0;
      priority if (ch >= CHAR_DEL) begin
         s.ok = 1'b0;
      end else if (ch >= "A" && ch <= "Z") begin
         t       = ch - 8'd65;
         s.value = t[5:0];
      end else if (ch >= "a" && ch <= "z") begin
         // 'a' maps to 26
         t       = ch - 8'd71;
         s.value = t[5:0];
      end else if (ch >= "0" && ch <= "9") begin
         // '0' maps to 52
         t       = ch + 8'd4;
         s.value = t[5:0];
      end else if (ch == {1'b0, cfg.symbol_62}) begin
         s.value = 6'd62;
      end else if (ch == {1'b0, cfg.symbol_63}) begin
         s.value = 6'd63;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

[rtl/b64d_step.sv]
// one character of decode: next group state and the results it causes
// depends on b64d_pkg

module b64d_step (
   input  b64d_pkg::cfg_type          cfg,
   input  b64d_pkg::dec_state_type    st,
   input  logic [7:0]                 ch,
   input  logic                       last,
   output b64d_pkg::dec_state_type    st_next,
   output b64d_pkg::result_group_type res
);

   b64d_pkg::sym_type      sym;
   b64d_pkg::err_code_type err;
   logic [1:0]             n;
   logic [23:0]            full;

   always_comb begin
      sym     = b64d_pkg::sym_decode(ch, cfg);
      full    = {st.acc, sym.value};
      err     = b64d_pkg::ERR_NONE;
      n       = 2'd0;
      st_next = st;
      res     = '0;

      if (st.drop) begin
         if (last) begin
            st_next = '0;
         end
      end else begin
         if (ch != b64d_pkg::CHAR_CR && ch != b64d_pkg::CHAR_LF) begin
            priority if (st.after_end) begin
               err = b64d_pkg::ERR_AFTER_END;
            end else if (st.pad_pending) begin
               if (ch == b64d_pkg::CHAR_PAD) begin
                  res.item[0].out_byte = st.acc[11:4];
                  n                    = 2'd1;
                  st_next.pad_pending  = 1'b0;
                  st_next.fill         = 2'd0;
                  st_next.acc          = '0;
                  st_next.after_end    = 1'b1;
               end else begin
                  err = b64d_pkg::ERR_MISSING_PAD;
               end
            end else if (cfg.padding_enabled && ch == b64d_pkg::CHAR_PAD && st.fill[1]) begin
               if (!st.fill[0]) begin
                  st_next.pad_pending = 1'b1;
               end else begin
                  res.item[0].out_byte = st.acc[17:10];
                  res.item[1].out_byte = st.acc[9:2];
                  n                    = 2'd2;
                  st_next.fill         = 2'd0;
                  st_next.acc          = '0;
                  st_next.after_end    = 1'b1;
               end
            end else if (!sym.ok) begin
               err = b64d_pkg::ERR_INVALID_CHAR;
            end else if (st.fill == 2'd3) begin
               res.item[0].out_byte = full[23:16];
               res.item[1].out_byte = full[15:8];
               res.item[2].out_byte = full[7:0];
               n                    = 2'd3;
               st_next.fill         = 2'd0;
               st_next.acc          = '0;
            end else begin
               st_next.acc  = full[b64d_pkg::ACC_W-1:0];
               st_next.fill = st.fill + 2'd1;
            end
         end

         if (err != b64d_pkg::ERR_NONE) begin
            // nothing else is emitted on an error beat, so it goes first
            res.item[0].kind      = b64d_pkg::KIND_ERROR;
            res.item[0].code      = err;
            res.item[0].offending = ch;
            n                     = 2'd1;
            if (last) begin
               st_next = '0;
            end else begin
               st_next.drop = 1'b1;
            end
         end else if (last) begin
            if (!st_next.after_end && (st_next.pad_pending || st_next.fill != 2'd0)) begin
               priority if (!cfg.padding_enabled && !st_next.pad_pending
                            && st_next.fill == 2'd2) begin
                  res.item[n].out_byte = st_next.acc[11:4];
                  n                    = n + 2'd1;
               end else if (!cfg.padding_enabled && !st_next.pad_pending
                            && st_next.fill == 2'd3) begin
                  res.item[n].out_byte       = st_next.acc[17:10];
                  res.item[n+2'd1].out_byte  = st_next.acc[9:2];
                  n                          = n + 2'd2;
               end else begin
                  res.item[n].kind = b64d_pkg::KIND_ERROR;
                  res.item[n].code = b64d_pkg::ERR_UNEXPECTED_END;
                  n                = n + 2'd1;
               end
            end
            st_next = '0;
         end
      end
      res.count = n;
   end

endmodule

[rtl/b64d_out_buf.sv]
// result buffer: holds the results of one character and hands them out one beat a cycle while rsp_ready is high
// depends on b64d_pkg

module b64d_out_buf (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  b64d_pkg::result_group_type group,
   output logic                       can_load,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output b64d_pkg::result_type       rsp_item,
   output logic                       rsp_last
);

   b64d_pkg::result_type [b64d_pkg::MAX_RESULTS-1:0] item_ff, item_in;
   logic [1:0] rem_ff, rem_in;
   logic [1:0] idx_ff, idx_in;
   logic       take;

   assign take      = rsp_valid && rsp_ready;
   assign rsp_valid = rem_ff != 2'd0;
   assign rsp_last  = rem_ff == 2'd1;
   assign rsp_item  = item_ff[idx_ff];
   // a new group may land as the last beat of the current one leaves
   assign can_load  = (rem_ff == 2'd0) || (rem_ff == 2'd1 && rsp_ready);

   always_comb begin
      item_in = item_ff;
      rem_in  = rem_ff;
      idx_in  = idx_ff;
      if (load) begin
         item_in = group.item;
         rem_in  = group.count;
         idx_in  = 2'd0;
      end else if (take) begin
         rem_in = rem_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff  <= idx_in;
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

endmodule

[rtl/base64_text_to_bytes_decoder_unit.sv]
// base64 text decoder: input register, decode step, result buffer
// depends on b64d_pkg, b64d_step, b64d_out_buf
//
// usage:
//   req channel: one text character per beat, req_end_of_message on the
//   last character of a message. CR and LF are skipped.
//   rsp channel: decoded bytes (rsp_result_kind 0) and error reports
//   (kind 1 with rsp_error_code / rsp_offending_char); rsp_last_of_run
//   marks the final result caused by one character.
//   csr port: write-only, index 0 padding enable, 1 symbol for 62,
//   2 symbol for 63; write only while idle.
// timing:
//   a character is captured in the input register, is decoded on its
//   way into the result buffer, and its first result is valid once the
//   buffer has registered it.
//   One character per cycle is taken while each causes at most one result
//   and rsp_ready stays high; a character that causes more results holds
//   the input side until the last of its results is being taken.
// reset: clears the group state, the buffer and both valids, and loads
//   padding on with '+' and '/' as the top symbols.
// stall: while rsp_ready is low and results are buffered, they hold, the input
//   register keeps its character and req_ready drops once that register is full.

module base64_text_to_bytes_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_text_char,
   input  logic                               req_end_of_message,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_result_kind,
   output logic [2:0]                         rsp_error_code,
   output logic [7:0]                         rsp_offending_char,
   output logic                               rsp_last_of_run,
   input  logic                               csr_write_enable,
   input  logic [b64d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [b64d_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   b64d_pkg::cfg_type          cfg_ff, cfg_in;
   b64d_pkg::dec_state_type    st_ff, st_in, st_next;
   b64d_pkg::result_group_type group;
   b64d_pkg::result_type       rsp_item;
   logic                       in_valid_ff, in_valid_in;
   logic [7:0]                 in_char_ff, in_char_in;
   logic                       in_last_ff, in_last_in;
   logic                       can_load;
   logic                       move;

   assign move      = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || move;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            b64d_pkg::CSR_PADDING_ENABLED: cfg_in.padding_enabled = csr_write_data[0];
            b64d_pkg::CSR_SYMBOL_62:       cfg_in.symbol_62       = csr_write_data;
            b64d_pkg::CSR_SYMBOL_63:       cfg_in.symbol_63       = csr_write_data;
            default:                       cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_text_char;
         in_last_in  = req_end_of_message;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
      st_in = move ? st_next : st_ff;
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_last_ff <= in_last_in;
      if (reset) begin
         in_valid_ff            <= 1'b0;
         st_ff                  <= '0;
         cfg_ff.padding_enabled <= 1'b1;
         cfg_ff.symbol_62       <= 7'd43;
         cfg_ff.symbol_63       <= 7'd47;
      end else begin
         in_valid_ff <= in_valid_in;
         st_ff       <= st_in;
         cfg_ff      <= cfg_in;
      end
   end

   b64d_step u_step (
      .cfg     (cfg_ff),
      .st      (st_ff),
      .ch      (in_char_ff),
      .last    (in_last_ff),
      .st_next (st_next),
      .res     (group)
   );

   b64d_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (move),
      .group     (group),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .rsp_last  (rsp_last_of_run)
   );

   assign rsp_out_byte       = rsp_item.out_byte;
   assign rsp_result_kind    = rsp_item.kind;
   assign rsp_error_code     = rsp_item.code;
   assign rsp_offending_char = rsp_item.offending;

endmodule
